// File: design/fnpll_pkg.sv
`default_nettype none
package fnpll_pkg;

  // widths of the datapath
  localparam int FREQ_W     = 33;
  localparam int DIVD_W     = 34;
  localparam int PFD_W      = 22;
  localparam int REF_W      = 26;
  localparam int CFG_DATA_W = 26;
  localparam int CFG_IDX_W  = 3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HIGH = 2'd1;
  localparam logic [1:0] ST_LOW  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHIP_VARIANT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_CLOCK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POWER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RF_ENABLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_PUMP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_CLK_DIV = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_DIV    = 3'd6;

  // band edges of the output divider
  localparam logic [FREQ_W-1:0] F_TOO_HIGH = 33'd4400000000;
  localparam logic [FREQ_W-1:0] F_BAND0    = 33'd2200000000;
  localparam logic [FREQ_W-1:0] F_BAND1    = 33'd1100000000;
  localparam logic [FREQ_W-1:0] F_BAND2    = 33'd550000000;
  localparam logic [FREQ_W-1:0] F_BAND3    = 33'd275000000;
  localparam logic [FREQ_W-1:0] F_LOW_OLD  = 33'd137500000;
  localparam logic [FREQ_W-1:0] F_BAND5    = 33'd68750000;
  localparam logic [FREQ_W-1:0] F_LOW_NEW  = 33'd35000000;

  // reference clock limits
  localparam logic [REF_W-1:0] REF_MIN       = 26'd10000000;
  localparam logic [REF_W-1:0] REF_MAX       = 26'd50000000;
  localparam logic [REF_W-1:0] REF_DBL_BELOW = 26'd30000000;

  // floor(n / 5) = (n * RECIP_DIV5) >> RECIP_SHIFT for any 32-bit n
  localparam logic [31:0] RECIP_DIV5  = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 34;

  // register reset values
  localparam logic                CHIP_VARIANT_RST = 1'b1;
  localparam logic [REF_W-1:0]    REF_CLOCK_RST    = 26'd25000000;
  localparam logic [1:0]          OUT_POWER_RST    = 2'd3;
  localparam logic                RF_ENABLE_RST    = 1'b1;
  localparam logic [3:0]          CHARGE_PUMP_RST  = 4'd15;
  localparam logic [7:0]          BAND_CLK_DIV_RST = 8'd4;
  localparam logic [11:0]         CLOCK_DIV_RST    = 12'd150;

  localparam int FRAC_MODULUS_DEF = 4095;
  localparam int QUEUE_DEPTH_DEF  = 2;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [2:0]        div_sel;
    logic [1:0]        status;
  } job_t;

  typedef struct packed {
    logic             chip_variant;
    logic [REF_W-1:0] ref_clock_hz;
    logic [1:0]       out_power;
    logic             rf_enable;
    logic [3:0]       charge_pump_code;
    logic [7:0]       band_clk_divide;
    logic [11:0]      clock_divide_value;
  } cfg_t;

endpackage
`default_nettype wire

// File: design/frac_n_pll_register_builder_core.sv
`default_nettype none
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------------
// in      | in        | in_valid / in_stall  | action, freq_hz
// out     | out       | out_valid / out_stall| reg_index, reg_word, status, last
// cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a tune transaction leaves the queue, then runs the pfd multiply, two divides (load,
// 17 steps of two quotient bits, result) and emits its words, index 5 down to 0; a
// rejected frequency goes straight from the queue to its single status word; the
// back end returns to idle between transactions
// the front takes a new transaction while the queue has room; in_stall is queue full
// out_stall holds the output register and stretches the emit phase
// reset is synchronous and restores the register defaults and stored frequency 0
module frac_n_pll_register_builder_core
  import fnpll_pkg::*;
#(
  parameter int FRAC_MODULUS = FRAC_MODULUS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  // request channel
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   action,
  input  wire  [FREQ_W-1:0]     freq_hz,
  // control word channel
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [2:0]            reg_index,
  output logic [31:0]           reg_word,
  output logic [1:0]            status,
  output logic                  last,
  // register write channel
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  job_t front_job;
  job_t q_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  // register writes land at any time; software is to write only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chip_variant       <= CHIP_VARIANT_RST;
      cfg.ref_clock_hz       <= REF_CLOCK_RST;
      cfg.out_power          <= OUT_POWER_RST;
      cfg.rf_enable          <= RF_ENABLE_RST;
      cfg.charge_pump_code   <= CHARGE_PUMP_RST;
      cfg.band_clk_divide    <= BAND_CLK_DIV_RST;
      cfg.clock_divide_value <= CLOCK_DIV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHIP_VARIANT: cfg.chip_variant       <= cfg_data[0];
        REG_REF_CLOCK:    cfg.ref_clock_hz       <= cfg_data[REF_W-1:0];
        REG_OUT_POWER:    cfg.out_power          <= cfg_data[1:0];
        REG_RF_ENABLE:    cfg.rf_enable          <= cfg_data[0];
        REG_CHARGE_PUMP:  cfg.charge_pump_code   <= cfg_data[3:0];
        REG_BAND_CLK_DIV: cfg.band_clk_divide    <= cfg_data[7:0];
        REG_CLOCK_DIV:    cfg.clock_divide_value <= cfg_data[11:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // front: picks the frequency, classifies the band, keeps the stored frequency
  fnpll_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .freq_hz      (freq_hz),
    .chip_variant (cfg.chip_variant),
    .q_full       (q_full),
    .push         (push),
    .job          (front_job)
  );

  // short queue between classification and word building
  fnpll_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .pop_job  (q_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: pfd, INT / FRAC divides, word packing and output register
  fnpll_back #(
    .FRAC_MOD (FRAC_MODULUS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .reg_index (reg_index),
    .reg_word  (reg_word),
    .status    (status),
    .last      (last)
  );

endmodule
`default_nettype wire

// File: design/fnpll_front.sv
`default_nettype none
module fnpll_front
  import fnpll_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               action,
  input  wire  [FREQ_W-1:0] freq_hz,
  input  wire               chip_variant,
  input  wire               q_full,
  output logic              push,
  output job_t              job
);

  logic [FREQ_W-1:0] stored_freq;
  logic [FREQ_W-1:0] f_sel;
  logic [2:0]        div_sel;
  logic [1:0]        status;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign f_sel    = action ? stored_freq : freq_hz;

  // band classification
  always_comb begin
    div_sel = 3'd0;
    status  = ST_OK;
    priority if (f_sel >= F_TOO_HIGH) begin
      status = ST_HIGH;
    end else if (chip_variant && f_sel <= F_LOW_NEW) begin
      status = ST_LOW;
    end else if (!chip_variant && f_sel <= F_LOW_OLD) begin
      status = ST_LOW;
    end else if (f_sel >= F_BAND0) begin
      div_sel = 3'd0;
    end else if (f_sel >= F_BAND1) begin
      div_sel = 3'd1;
    end else if (f_sel >= F_BAND2) begin
      div_sel = 3'd2;
    end else if (f_sel >= F_BAND3) begin
      div_sel = 3'd3;
    end else if (!chip_variant || f_sel >= F_LOW_OLD) begin
      div_sel = 3'd4;
    end else if (f_sel >= F_BAND5) begin
      div_sel = 3'd5;
    end else begin
      div_sel = 3'd6;
    end
  end

  assign job.freq    = f_sel;
  assign job.div_sel = div_sel;
  assign job.status  = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_freq <= '0;
    end else if (push && status == ST_OK) begin
      stored_freq <= f_sel;
    end
  end

endmodule
`default_nettype wire

// File: design/fnpll_queue.sv
`default_nettype none
module fnpll_queue
  import fnpll_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire   clk,
  input  wire   rst,
  input  wire   push,
  input  job_t  push_job,
  input  wire   pop,
  output job_t  pop_job,
  output logic  full,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: design/fnpll_div.sv
`default_nettype none
module fnpll_div
  import fnpll_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire  [DIVD_W-1:0] dividend,
  input  wire  [PFD_W-1:0]  divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient,
  output logic [PFD_W-1:0]  remainder
);

  // two restoring steps per cycle
  localparam int STEPS = DIVD_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [PFD_W-1:0]  dvs;
  logic [DIVD_W-1:0] q_next;
  logic [PFD_W-1:0]  r_next;

  always_comb begin
    logic [PFD_W:0] t;
    q_next = quotient;
    r_next = remainder;
    t      = '0;
    for (int i = 0; i < 2; i++) begin
      t      = {r_next, q_next[DIVD_W-1]};
      q_next = {q_next[DIVD_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t         = t - {1'b0, dvs};
        q_next[0] = 1'b1;
      end
      r_next = t[PFD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= q_next;
      remainder <= r_next;
    end
  end

endmodule
`default_nettype wire

// File: design/fnpll_back.sv
`default_nettype none
module fnpll_back
  import fnpll_pkg::*;
#(
  parameter int FRAC_MOD = FRAC_MODULUS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  cfg_t         cfg,
  input  wire          q_empty,
  input  job_t         q_job,
  output logic         pop,
  output logic         out_valid,
  input  wire          out_stall,
  output logic [2:0]   reg_index,
  output logic [31:0]  reg_word,
  output logic [1:0]   status,
  output logic         last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL5  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_WAIT1 = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_WAIT2 = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [11:0] FM12    = 12'(FRAC_MOD);
  localparam int          MUL5_W  = 25 + 32;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [2:0]        emit_index;
  job_t              job;
  logic [REF_W-1:0]  ref_clamp;
  logic              dbl;
  logic [REF_W:0]    ref_x;
  logic [24:0]       ref_q;
  logic [MUL5_W-1:0] mul5;
  logic [PFD_W-1:0]  pfd;
  logic [FREQ_W-1:0] prod;
  logic [DIVD_W-1:0] fmul;
  logic [15:0]       intv;
  logic [11:0]       fracv;
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;
  logic [PFD_W-1:0]  div_rem;
  logic              out_free;
  logic [31:0]       word_sel;

  // phase detector frequency: clamp, optional doubler, then / 20
  always_comb begin
    ref_clamp = cfg.ref_clock_hz;
    if (cfg.ref_clock_hz < REF_MIN) begin
      ref_clamp = REF_MIN;
    end else if (cfg.ref_clock_hz > REF_MAX) begin
      ref_clamp = REF_MAX;
    end
  end

  assign dbl   = (ref_clamp < REF_DBL_BELOW);
  assign ref_x = dbl ? {ref_clamp, 1'b0} : {1'b0, ref_clamp};
  assign ref_q = ref_x[REF_W:2];
  assign pfd   = mul5[PFD_W+RECIP_SHIFT-1:RECIP_SHIFT];
  assign prod  = job.freq << job.div_sel;

  assign pop          = (state == S_IDLE) && !q_empty;
  assign div_start    = (state == S_DIV1) || (state == S_DIV2);
  assign div_dividend = (state == S_DIV1) ? {1'b0, prod} : fmul;
  assign out_free     = !out_valid || !out_stall;

  fnpll_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (pfd),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // control word packing
  always_comb begin
    word_sel = '0;
    unique case (emit_index)
      3'd0: word_sel = {1'b0, intv, fracv, 3'd0};
      3'd1: word_sel = (32'd1 << 15) | (32'(FM12) << 3) | 32'd1;
      3'd2: word_sel = (32'(dbl) << 25) | (32'd1 << 24) | (32'd10 << 14)
                     | (32'(cfg.charge_pump_code) << 9) | (32'd1 << 8)
                     | (32'd1 << 6) | 32'd2;
      3'd3: word_sel = (32'(cfg.clock_divide_value) << 3) | 32'd3;
      3'd4: word_sel = (32'd1 << 23) | (32'(job.div_sel) << 20)
                     | (32'(cfg.band_clk_divide) << 12) | (32'd1 << 10)
                     | (32'(cfg.rf_enable) << 5) | (32'(cfg.out_power) << 3) | 32'd4;
      3'd5: word_sel = (32'd1 << 22) | (32'd3 << 19) | 32'd5;
      default: word_sel = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          state_next = (q_job.status == ST_OK) ? S_MUL5 : S_EMIT;
        end
      end
      S_MUL5:  state_next = S_DIV1;
      S_DIV1:  state_next = S_WAIT1;
      S_WAIT1: state_next = div_done ? S_DIV2 : S_WAIT1;
      S_DIV2:  state_next = S_WAIT2;
      S_WAIT2: state_next = div_done ? S_EMIT : S_WAIT2;
      S_EMIT: begin
        if (out_free && (job.status != ST_OK || emit_index == 3'd0)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      emit_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_WAIT2 && div_done) begin
        emit_index <= 3'd5;
      end
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
        if (job.status == ST_OK && emit_index != 3'd0) begin
          emit_index <= emit_index - 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
    if (state == S_MUL5) begin
      mul5 <= MUL5_W'(ref_q) * MUL5_W'(RECIP_DIV5);
    end
    if (state == S_WAIT1 && div_done) begin
      intv <= div_quo[15:0];
      fmul <= DIVD_W'(div_rem) * DIVD_W'(FM12);
    end
    if (state == S_WAIT2 && div_done) begin
      fracv <= div_quo[11:0];
    end
    if (state == S_EMIT && out_free) begin
      if (job.status == ST_OK) begin
        reg_index <= emit_index;
        reg_word  <= word_sel;
        status    <= ST_OK;
        last      <= (emit_index == 3'd0);
      end else begin
        reg_index <= 3'd0;
        reg_word  <= '0;
        status    <= job.status;
        last      <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_err_single: assert property (@(posedge clk) disable iff (rst)
      out_valid && status != ST_OK |-> last && reg_index == 3'd0 && reg_word == '0)
    else $error("rejected transaction not a single empty word");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
      out_valid && last |-> reg_index == 3'd0)
    else $error("last word is not index 0");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
      div_done |-> state == S_WAIT1 || state == S_WAIT2)
    else $error("divider finished outside a wait state");
`endif

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fnpll_pkg::*;

  // run limits: cycle counts, report cap and chunk size
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 10;
  localparam int CHUNK_ITEMS  = 25;

  // request actions
  localparam logic ACT_TUNE   = 1'b0;
  localparam logic ACT_RESEND = 1'b1;

  localparam longint unsigned FREQ_MASK = 64'h1_FFFF_FFFF;

  // one control word as it leaves the block
  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] word;
    logic [1:0]  st;
    logic        last;
  } ctrl_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  action = 1'b0;
  logic [FREQ_W-1:0]     freq_hz = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            reg_index;
  logic [31:0]           reg_word;
  logic [1:0]            status;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // mirror of the block: register file and the last good tune
  cfg_t shadow_cfg = '{CHIP_VARIANT_RST, REF_CLOCK_RST, OUT_POWER_RST, RF_ENABLE_RST,
                       CHARGE_PUMP_RST, BAND_CLK_DIV_RST, CLOCK_DIV_RST};
  logic [FREQ_W-1:0] tuned_freq = '0;

  // control words still owed by the block, oldest first
  ctrl_word_t expected_words[$];

  int          mismatch_count = 0;
  int          words_checked  = 0;
  int          requests_sent  = 0;
  int          rejects_seen   = 0;
  int unsigned cycle_count    = 0;

  // idle mix of the current phase, in percent of cycles
  int send_gap_pct = 0;
  int stall_pct    = 0;

  // long output hold: the test bumps hold_requests, the stall process counts it out
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  frac_n_pll_register_builder_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .freq_hz   (freq_hz),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .reg_index (reg_index),
    .reg_word  (reg_word),
    .status    (status),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // output back-pressure: a long hold when asked, otherwise random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare every accepted control word against the oldest expectation
  always @(posedge clk) begin : check_words
    ctrl_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("tb_top: unexpected word at cycle %0d: idx %0d word %h status %0d last %0b",
                   cycle_count, reg_index, reg_word, status, last);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (reg_index !== want.idx || reg_word !== want.word ||
            status !== want.st || last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"tb_top: mismatch at cycle %0d: got idx %0d word %h status %0d last %0b,",
                      " expected idx %0d word %h status %0d last %0b"},
                     cycle_count, reg_index, reg_word, status, last,
                     want.idx, want.word, want.st, want.last);
        end
      end
    end
  end

  // work out the words one request produces and update the stored frequency
  task automatic predict_words(input logic act, input logic [FREQ_W-1:0] req);
    logic [FREQ_W-1:0] f;
    logic [1:0]        st;
    logic [2:0]        div;
    logic              dbl;
    longint unsigned   refc, pfd, prod, intv, fracv;
    logic [31:0]       w [6];
    f = (act == ACT_RESEND) ? tuned_freq : req;
    st = ST_OK;
    // output divider from the octave bands
    if (f >= F_BAND0)      div = 3'd0;
    else if (f >= F_BAND1) div = 3'd1;
    else if (f >= F_BAND2) div = 3'd2;
    else if (f >= F_BAND3) div = 3'd3;
    else                   div = 3'd4;
    if (f >= F_TOO_HIGH) begin
      st = ST_HIGH;
    end else if (shadow_cfg.chip_variant) begin
      if (f < F_LOW_OLD) div = 3'd5;
      if (f < F_BAND5) div = 3'd6;
      if (f <= F_LOW_NEW) st = ST_LOW;
    end else if (f <= F_LOW_OLD) begin
      st = ST_LOW;
    end
    if (st != ST_OK) begin
      // rejected: one bare status word, stored frequency untouched
      expected_words.push_back('{idx: 3'd0, word: 32'd0, st: st, last: 1'b1});
      rejects_seen++;
    end else begin
      // phase detector: clamp, doubler below 30 MHz, R = 10, then /2
      refc = shadow_cfg.ref_clock_hz;
      if (refc < REF_MIN) refc = REF_MIN;
      if (refc > REF_MAX) refc = REF_MAX;
      dbl = (refc < REF_DBL_BELOW);
      pfd = dbl ? (refc * 2) / 20 : refc / 20;
      // product stays 33 bits wide
      prod = f;
      prod = (prod << div) & FREQ_MASK;
      intv = prod / pfd;
      fracv = ((prod % pfd) * FRAC_MODULUS_DEF) / pfd;
      w[0] = {1'b0, 16'(intv), 12'(fracv), 3'd0};
      w[1] = (32'd1 << 15) | ((32'(FRAC_MODULUS_DEF) & 32'hFFF) << 3) | 32'd1;
      w[2] = (32'(dbl) << 25) | (32'd1 << 24) | (32'd10 << 14)
           | (32'(shadow_cfg.charge_pump_code) << 9) | (32'd1 << 8) | (32'd1 << 6) | 32'd2;
      w[3] = (32'(shadow_cfg.clock_divide_value) << 3) | 32'd3;
      // vco power-down at bit 11 stays clear
      w[4] = (32'd1 << 23) | (32'(div) << 20) | (32'(shadow_cfg.band_clk_divide) << 12)
           | (32'd1 << 10) | (32'(shadow_cfg.rf_enable) << 5)
           | (32'(shadow_cfg.out_power) << 3) | 32'd4;
      w[5] = (32'd1 << 22) | (32'd3 << 19) | 32'd5;
      for (int k = 5; k >= 0; k--)
        expected_words.push_back('{idx: 3'(k), word: w[k], st: ST_OK, last: (k == 0)});
      tuned_freq = f;
    end
  endtask

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic act, input logic [FREQ_W-1:0] f);
    if (cfg_valid) cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    freq_hz <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_words(act, f);
    requests_sent++;
  endtask

  // register write; only called with nothing in flight
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CHIP_VARIANT: shadow_cfg.chip_variant = val[0];
      REG_REF_CLOCK:    shadow_cfg.ref_clock_hz = val[REF_W-1:0];
      REG_OUT_POWER:    shadow_cfg.out_power = val[1:0];
      REG_RF_ENABLE:    shadow_cfg.rf_enable = val[0];
      REG_CHARGE_PUMP:  shadow_cfg.charge_pump_code = val[3:0];
      REG_BAND_CLK_DIV: shadow_cfg.band_clk_divide = val[7:0];
      REG_CLOCK_DIV:    shadow_cfg.clock_divide_value = val[11:0];
      default: ;
    endcase
  endtask

  // stop offering and wait for every owed word
  task automatic wait_drain();
    in_valid <= 1'b0;
    if (cfg_valid) cfg_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [FREQ_W-1:0] band_edge(input int i);
    case (i)
      0:       return F_LOW_NEW;
      1:       return F_BAND5;
      2:       return F_LOW_OLD;
      3:       return F_BAND3;
      4:       return F_BAND2;
      5:       return F_BAND1;
      6:       return F_BAND0;
      default: return F_TOO_HIGH;
    endcase
  endfunction

  // mostly in-band values, spread over every octave, plus edges and noise
  function automatic logic [FREQ_W-1:0] random_freq();
    int unsigned     pick;
    int              b;
    longint unsigned lo, span, r;
    pick = $urandom_range(99);
    r = {$urandom, $urandom};
    b = $urandom_range(6);
    lo = band_edge(b);
    if (pick < 65) begin
      span = band_edge(b + 1) - lo;
      return FREQ_W'(lo + r % span);
    end else if (pick < 80) begin
      lo = band_edge($urandom_range(7));
      return FREQ_W'(lo + $urandom_range(6) - 3);
    end else if (pick < 90) begin
      return FREQ_W'(r);
    end
    return FREQ_W'(r % (F_LOW_NEW + 1));
  endfunction

  // new random register file, reference clock often at or past its limits
  task automatic shuffle_registers();
    logic [CFG_DATA_W-1:0] refv;
    case ($urandom_range(9))
      0:       refv = '0;
      1:       refv = 26'd9999999;
      2:       refv = 26'd29999999;
      3:       refv = REF_DBL_BELOW;
      4:       refv = REF_MAX;
      5:       refv = '1;
      default: refv = CFG_DATA_W'($urandom_range(50000000, 10000000));
    endcase
    set_reg(REG_CHIP_VARIANT, CFG_DATA_W'($urandom));
    set_reg(REG_REF_CLOCK, refv);
    set_reg(REG_OUT_POWER, CFG_DATA_W'($urandom));
    set_reg(REG_RF_ENABLE, CFG_DATA_W'($urandom));
    set_reg(REG_CHARGE_PUMP, CFG_DATA_W'($urandom));
    set_reg(REG_BAND_CLK_DIV, CFG_DATA_W'($urandom));
    set_reg(REG_CLOCK_DIV, CFG_DATA_W'($urandom));
  endtask

  task automatic send_random();
    send_request(($urandom_range(99) < 15) ? ACT_RESEND : ACT_TUNE, random_freq());
  endtask

  // random traffic in chunks, registers reshuffled between chunks
  task automatic run_traffic(input int gap_p, input int stall_p, input int count);
    send_gap_pct = gap_p;
    stall_pct = stall_p;
    for (int i = 0; i < count; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        wait_drain();
        shuffle_registers();
      end
      send_random();
    end
    wait_drain();
  endtask

  // reset registers: every divider band edge, both rejects, resend before any tune
  task automatic test_band_edges();
    send_request(ACT_RESEND, 33'h1_FFFF_FFFF);
    send_request(ACT_TUNE, 33'd0);
    send_request(ACT_TUNE, F_LOW_NEW);
    send_request(ACT_TUNE, F_LOW_NEW + 1);
    send_request(ACT_TUNE, F_BAND5 - 1);
    send_request(ACT_TUNE, F_BAND5);
    send_request(ACT_TUNE, F_LOW_OLD);
    send_request(ACT_TUNE, F_BAND3);
    send_request(ACT_TUNE, F_BAND2);
    send_request(ACT_TUNE, F_BAND1);
    send_request(ACT_TUNE, F_BAND0 - 1);
    send_request(ACT_TUNE, F_BAND0);
    send_request(ACT_TUNE, F_TOO_HIGH - 1);
    send_request(ACT_TUNE, F_TOO_HIGH);
    send_request(ACT_TUNE, 33'h1_FFFF_FFFF);
    wait_drain();
  endtask

  // older variant has its low bound at 137.5 MHz
  task automatic test_old_variant();
    set_reg(REG_CHIP_VARIANT, '0);
    send_request(ACT_TUNE, F_LOW_OLD);
    send_request(ACT_TUNE, F_LOW_OLD + 1);
    send_request(ACT_RESEND, '0);
    wait_drain();
    set_reg(REG_CHIP_VARIANT, 26'd1);
  endtask

  // every field but the chip variant at both ends; resend picks up the new registers
  task automatic test_register_extremes();
    set_reg(REG_REF_CLOCK, '0);
    set_reg(REG_OUT_POWER, '0);
    set_reg(REG_RF_ENABLE, '0);
    set_reg(REG_CHARGE_PUMP, '0);
    set_reg(REG_BAND_CLK_DIV, '0);
    set_reg(REG_CLOCK_DIV, '0);
    send_request(ACT_RESEND, '0);
    wait_drain();
    set_reg(REG_REF_CLOCK, '1);
    set_reg(REG_OUT_POWER, 26'd3);
    set_reg(REG_RF_ENABLE, 26'd1);
    set_reg(REG_CHARGE_PUMP, 26'd15);
    set_reg(REG_BAND_CLK_DIV, 26'd255);
    set_reg(REG_CLOCK_DIV, 26'd4095);
    send_request(ACT_RESEND, '0);
    wait_drain();
    set_reg(REG_REF_CLOCK, 26'd29999999);
    send_request(ACT_TUNE, 33'd1000000000);
    wait_drain();
    set_reg(REG_REF_CLOCK, REF_DBL_BELOW);
    send_request(ACT_RESEND, '0);
    wait_drain();
  endtask

  task automatic test_no_idling();
    run_traffic(0, 0, 100);
  endtask

  task automatic test_sender_gaps();
    run_traffic(49, 0, 100);
  endtask

  task automatic test_receiver_stalls();
    run_traffic(0, 49, 100);
  endtask

  task automatic test_both_idle();
    run_traffic(16, 16, 100);
  endtask

  // output held for a long stretch while requests keep coming, so the input
  // queue fills and stalls; then the sender waits for everything to come out
  task automatic test_output_hold();
    send_gap_pct = 0;
    stall_pct = 0;
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 30; i++) send_random();
    wait_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_band_edges();
    test_old_variant();
    test_register_extremes();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_output_hold();
    wait_drain();
    // catch stray words after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) mismatch_count += expected_words.size();
    $display("tb_top: %0d requests sent, %0d rejected, %0d control words checked",
             requests_sent, rejects_seen, words_checked);
    $display("tb_top: band edges, both variants, register limits, four idle mixes, long hold");
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
